// File: src/crm_pkg.sv
package crm_pkg;

  localparam int CRM_MAX_BOXES = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ATTACH = 2'd1,
    OP_CLICK  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  typedef enum logic {
    MS_IDLE,
    MS_SCAN
  } match_state_t;

  // query token that walks down the cell row
  typedef struct packed {
    logic        valid;
    logic [15:0] px;
    logic [15:0] py;
    logic        hit;
    logic        own_valid;
    logic [3:0]  own;
  } tok_t;

  // write bus broadcast to every cell, enables are per cell
  typedef struct packed {
    logic        add_en;
    logic        attach_en;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [3:0]  owner;
  } cell_wr_t;

  function automatic logic [1:0] pick_button(input logic [2:0] mask);
    logic [1:0] code;
    if (mask[0]) begin
      code = BTN_LEFT;
    end else if (mask[1]) begin
      code = BTN_RIGHT;
    end else begin
      code = BTN_MIDDLE;
    end
    return code;
  endfunction

endpackage

// File: src/crm_in_if.sv
interface crm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic [3:0]  box_index;
  logic [3:0]  owner_id;
  logic [2:0]  button_mask;

  modport source (
    output valid, operation, pos_x, pos_y, box_width, box_height, box_index,
           owner_id, button_mask,
    input  ready
  );

  modport sink (
    input  valid, operation, pos_x, pos_y, box_width, box_height, box_index,
           owner_id, button_mask,
    output ready
  );
endinterface

// File: src/crm_out_if.sv
interface crm_out_if;
  logic       valid;
  logic       ready;
  logic       table_full;
  logic [3:0] new_index;
  logic       hit;
  logic       owner_valid;
  logic [3:0] owner_out;
  logic [1:0] button_code;

  modport source (
    output valid, table_full, new_index, hit, owner_valid, owner_out, button_code,
    input  ready
  );

  modport sink (
    input  valid, table_full, new_index, hit, owner_valid, owner_out, button_code,
    output ready
  );
endinterface

// File: src/crm_cell.sv
module crm_cell
  import crm_pkg::*;
#(
  parameter int CW       = 5,
  parameter int CELL_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_wr_t      wr,
  input  logic [CW-1:0] count,
  input  tok_t          tok_in,
  output tok_t          tok_out
);

  logic [15:0] left_r;
  logic [15:0] top_r;
  logic [15:0] right_r;
  logic [15:0] bottom_r;
  logic        own_valid_r;
  logic [3:0]  own_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        in_use;
  logic        inside_box;

  assign in_use     = CW'(CELL_IDX) < count;
  assign inside_box = (tok_in.px >= left_r) && (tok_in.px <= right_r) &&
                      (tok_in.py >= top_r)  && (tok_in.py <= bottom_r);

  always_comb begin
    tok_nxt = tok_in;
    // first containing box wins, later cells just pass the token on
    if (tok_in.valid && !tok_in.hit && in_use && inside_box) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.own_valid = own_valid_r;
      tok_nxt.own       = own_valid_r ? own_r : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.add_en) begin
      left_r      <= wr.left;
      top_r       <= wr.top;
      right_r     <= wr.right;
      bottom_r    <= wr.bottom;
      own_valid_r <= 1'b0;
    end else if (wr.attach_en) begin
      own_valid_r <= 1'b1;
      own_r       <= wr.owner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: src/click_region_matcher.sv
// click region matcher: first-match rectangle hit test over a row of box cells
//
// in_ch carries one operation per beat: add a box, attach a box to a widget,
// or a click query. out_ch returns exactly one result beat per input beat.
// add and attach: the result is registered in the cycle after the input beat.
// click: the query token walks the row of MAX_BOXES cells, one cell per cycle,
// and the result is loaded into the output register when the token leaves the
// last cell.
// one item is in flight at a time; in_ch.ready is low while a click scans.
// the next item is taken in the same cycle that out_ch hands over the result.
// reset clears the box count, the scan state and the output valid flag; box
// contents are not cleared, slots above the count are never matched.
// when out_ch stalls, the result holds in the output register and in_ch
// waits until the result beat is taken.
module click_region_matcher
  import crm_pkg::*;
#(
  parameter int MAX_BOXES = CRM_MAX_BOXES
) (
  input  logic      clk,
  input  logic      rst_n,
  crm_in_if.sink    in_ch,
  crm_out_if.source out_ch
);

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  match_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    btn_r;

  logic          out_valid_r;
  logic          table_full_r;
  logic [3:0]    new_index_r;
  logic          hit_r;
  logic          owner_valid_r;
  logic [3:0]    owner_out_r;
  logic [1:0]    button_code_r;

  logic          in_ready;
  logic          acc;
  op_t           op;
  logic          full;
  logic          do_add;
  logic          do_attach;
  logic [IW-1:0] attach_slot;
  logic [IW+3:0] attach_ext;
  logic [CW+3:0] count_ext;
  cell_wr_t      wr_base;
  cell_wr_t      wr [MAX_BOXES];
  tok_t          tok [MAX_BOXES+1];
  tok_t          tail;

  assign op         = op_t'(in_ch.operation);
  assign in_ready   = (state_r == MS_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc        = in_ch.valid && in_ready;
  assign full       = count_r >= CW'(MAX_BOXES);
  assign do_add     = acc && (op == OP_ADD) && !full;
  assign do_attach  = acc && (op == OP_ATTACH) &&
                      ({28'd0, in_ch.box_index} < 32'(MAX_BOXES));
  assign attach_ext = {{IW{1'b0}}, in_ch.box_index};
  assign attach_slot = attach_ext[IW-1:0];
  assign count_ext  = {4'd0, count_r};
  assign in_ch.ready = in_ready;

  always_comb begin
    wr_base           = '0;
    wr_base.left      = in_ch.pos_x;
    wr_base.top       = in_ch.pos_y;
    wr_base.right     = in_ch.pos_x + in_ch.box_width;
    wr_base.bottom    = in_ch.pos_y + in_ch.box_height;
    wr_base.owner     = in_ch.owner_id;
  end

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = acc && (op == OP_CLICK);
    tok[0].px        = in_ch.pos_x;
    tok[0].py        = in_ch.pos_y;
  end

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    always_comb begin
      wr[i]           = wr_base;
      wr[i].add_en    = do_add && (count_r[IW-1:0] == IW'(i));
      wr[i].attach_en = do_attach && (attach_slot == IW'(i));
    end

    crm_cell #(
      .CW       (CW),
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr[i]),
      .count   (count_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tail = tok[MAX_BOXES];

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      MS_IDLE: begin
        if (acc && (op == OP_CLICK)) begin
          state_nxt = MS_SCAN;
        end
        if (do_add) begin
          count_nxt = count_r + CW'(1);
        end
      end
      MS_SCAN: begin
        if (tail.valid) begin
          state_nxt = MS_IDLE;
        end
      end
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (op == OP_CLICK)) begin
      btn_r <= pick_button(in_ch.button_mask);
    end
  end

  // output register; the row is empty whenever an add or attach result lands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail.valid) begin
      out_valid_r   <= 1'b1;
      table_full_r  <= 1'b0;
      new_index_r   <= 4'd0;
      hit_r         <= tail.hit;
      owner_valid_r <= tail.own_valid;
      owner_out_r   <= tail.own;
      button_code_r <= btn_r;
    end else if (acc && (op != OP_CLICK)) begin
      out_valid_r   <= 1'b1;
      table_full_r  <= (op == OP_ADD) && full;
      new_index_r   <= do_add ? count_ext[3:0] : 4'd0;
      hit_r         <= 1'b0;
      owner_valid_r <= 1'b0;
      owner_out_r   <= 4'd0;
      button_code_r <= 2'd0;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.table_full  = table_full_r;
  assign out_ch.new_index   = new_index_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.owner_valid = owner_valid_r;
  assign out_ch.owner_out   = owner_out_r;
  assign out_ch.button_code = button_code_r;

`ifndef NO_ASSERTIONS
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MS_SCAN) |-> !in_ch.ready)
    else $error("input taken while a click scan is running");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BOXES))
    else $error("box count beyond table size");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == MS_SCAN) && !out_valid_r)
    else $error("scan result with no scan running or output busy");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |=> (state_r == MS_IDLE) && out_valid_r)
    else $error("scan result not loaded into output register");
`endif

endmodule
